FILE: src/vcs_pkg.sv
`default_nettype none

package vcs_pkg;

    localparam int FIELD_WIDTH = 16;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] first_x;
        logic signed [FIELD_WIDTH-1:0] first_y;
        logic signed [FIELD_WIDTH-1:0] first_z;
        logic signed [FIELD_WIDTH-1:0] second_x;
        logic signed [FIELD_WIDTH-1:0] second_y;
        logic signed [FIELD_WIDTH-1:0] second_z;
    } request_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] cosine;
        logic                          zero_vector;
    } result_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } tag_t;

endpackage

`default_nettype wire

FILE: src/vcs_front.sv
`default_nettype none

module vcs_front #(
    parameter int CW = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire vcs_pkg::request_t  request,
    output vcs_pkg::tag_t           tag,
    output logic [4*CW-1:0]         norm_prod,
    output logic [4*CW-1:0]         dot_sq
);

    localparam int NW = 2 * CW;

    logic signed [CW-1:0] a_reg [3];
    logic signed [CW-1:0] b_reg [3];
    logic                 v0_reg;

    logic [NW-1:0]        sqa_reg [3];
    logic [NW-1:0]        sqb_reg [3];
    logic signed [NW-1:0] crs_reg [3];
    logic                 v1_reg;

    logic [NW-1:0]        na_reg;
    logic [NW-1:0]        nb_reg;
    logic [NW-1:0]        dmag_reg;
    logic                 neg2_reg;
    logic                 zero2_reg;
    logic                 v2_reg;

    logic [4*CW-1:0]      prod_reg;
    logic [4*CW-1:0]      dsq_reg;
    logic                 v3_reg;
    logic                 neg3_reg;
    logic                 zero3_reg;

    logic [NW-1:0]        na_next;
    logic [NW-1:0]        nb_next;
    logic signed [NW:0]   dot_next;

    always_comb
    begin
        na_next  = sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
        nb_next  = sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
        dot_next = {crs_reg[0][NW-1], crs_reg[0]}
                 + {crs_reg[1][NW-1], crs_reg[1]} + {crs_reg[2][NW-1], crs_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0] <= CW'($unsigned(request.first_x));
        a_reg[1] <= CW'($unsigned(request.first_y));
        a_reg[2] <= CW'($unsigned(request.first_z));
        b_reg[0] <= CW'($unsigned(request.second_x));
        b_reg[1] <= CW'($unsigned(request.second_y));
        b_reg[2] <= CW'($unsigned(request.second_z));
        for (int i = 0; i < 3; i++)
        begin
            sqa_reg[i] <= $unsigned(NW'(a_reg[i]) * NW'(a_reg[i]));
            sqb_reg[i] <= $unsigned(NW'(b_reg[i]) * NW'(b_reg[i]));
            crs_reg[i] <= NW'(a_reg[i]) * NW'(b_reg[i]);
        end
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        neg2_reg  <= dot_next[NW];
        dmag_reg  <= dot_next[NW] ? NW'(-dot_next) : NW'(dot_next);
        zero2_reg <= (na_next == '0) || (nb_next == '0);
        prod_reg  <= (4*CW)'(na_reg) * (4*CW)'(nb_reg);
        dsq_reg   <= (4*CW)'(dmag_reg) * (4*CW)'(dmag_reg);
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
    end

    assign tag       = '{valid: v3_reg, neg: neg3_reg, zero: zero3_reg};
    assign norm_prod = prod_reg;
    assign dot_sq    = dsq_reg;

endmodule

`default_nettype wire

FILE: src/vcs_div_cell.sv
`default_nettype none

module vcs_div_cell #(
    parameter int DW = 64,
    parameter int QW = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vcs_pkg::tag_t tag_in,
    input  wire logic [DW:0]   rem_in,
    input  wire logic          shift_in,
    input  wire logic [DW-1:0] divisor_in,
    input  wire logic [QW-1:0] quo_in,
    output vcs_pkg::tag_t      tag_out,
    output logic [DW:0]        rem_out,
    output logic [DW-1:0]      divisor_out,
    output logic [QW-1:0]      quo_out
);

    logic            valid_reg;
    logic            neg_reg;
    logic            zero_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   divisor_reg;
    logic [QW-1:0]   quo_reg;

    logic [DW:0]     trial;
    logic            fits;

    always_comb
    begin
        trial = {rem_in[DW-1:0], shift_in};
        fits  = trial >= {1'b0, divisor_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= tag_in.neg;
        zero_reg     <= tag_in.zero;
        rem_reg      <= fits ? trial - {1'b0, divisor_in} : trial;
        divisor_reg  <= divisor_in;
        quo_reg      <= {quo_in[QW-2:0], fits};
    end

    assign tag_out     = '{valid: valid_reg, neg: neg_reg, zero: zero_reg};
    assign rem_out     = rem_reg;
    assign divisor_out = divisor_reg;
    assign quo_out     = quo_reg;

endmodule

`default_nettype wire

FILE: src/vcs_sqrt_cell.sv
`default_nettype none

module vcs_sqrt_cell #(
    parameter int QW = 31,
    parameter int K  = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vcs_pkg::tag_t tag_in,
    input  wire logic [QW-1:0] rad_in,
    input  wire logic [QW-1:0] root_in,
    input  wire logic [QW-1:0] rsq_in,
    output vcs_pkg::tag_t      tag_out,
    output logic [QW-1:0]      rad_out,
    output logic [QW-1:0]      root_out,
    output logic [QW-1:0]      rsq_out
);

    localparam logic [QW+1:0] ONE = (QW+2)'(1);

    logic            valid_reg;
    logic            neg_reg;
    logic            zero_reg;
    logic [QW-1:0]   rad_reg;
    logic [QW-1:0]   root_reg;
    logic [QW-1:0]   rsq_reg;

    logic [QW+1:0]   trial_sq;
    logic            fits;

    always_comb
    begin
        trial_sq = (QW+2)'(rsq_in) + ((QW+2)'(root_in) << (K + 1)) + (ONE << (2 * K));
        fits     = trial_sq <= (QW+2)'(rad_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= tag_in.neg;
        zero_reg     <= tag_in.zero;
        rad_reg      <= rad_in;
        root_reg     <= fits ? (root_in | QW'(ONE << K)) : root_in;
        rsq_reg      <= fits ? QW'(trial_sq) : rsq_in;
    end

    assign tag_out  = '{valid: valid_reg, neg: neg_reg, zero: zero_reg};
    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rsq_out  = rsq_reg;

endmodule

`default_nettype wire

FILE: src/vector3_cosine_similarity.sv
`default_nettype none

// Cosine of the angle between two 3D integer vectors, in signed Q1.FRACTION_BITS.
// A request is taken at each rising edge where start is high and busy is low.
// Busy is never raised, so a new request may be issued in every cycle.
// The answer appears on result for one cycle with done high, in request order.
// The receiver cannot stall the block; each result must be captured when done is high.
// The datapath is a front end for squares, dot product and their products,
// then a chain of restoring divider cells (one quotient bit per cell) and a
// chain of square-root cells (one root bit per cell), one request per cell.
// The result is the exact truncated cosine; +1.0 saturates to the top code.
// When either vector is all zero, zero_vector is set and cosine is 0.
// Reset clears all pipeline valid bits, so no result appears until new requests.

module vector3_cosine_similarity #(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vcs_pkg::request_t request,
    output logic                   done,
    output vcs_pkg::result_t       result
);

    localparam int DW  = 4 * COORD_WIDTH;
    localparam int QW  = 2 * FRACTION_BITS + 1;
    localparam int FW  = vcs_pkg::FIELD_WIDTH;
    localparam int LAT = 3 * FRACTION_BITS + 7;
    localparam longint unsigned FULL = 64'd1 << FRACTION_BITS;
    localparam longint unsigned TOP_POS = (FULL - 64'd1 > 64'd32767) ? 64'd32767 : FULL - 64'd1;
    localparam longint unsigned TOP_NEG = (FULL > 64'd32768) ? 64'd32768 : FULL;

    vcs_pkg::tag_t   front_tag;
    logic [DW-1:0]   norm_prod;
    logic [DW-1:0]   dot_sq;

    vcs_pkg::tag_t   d_tag  [QW+1];
    logic [DW:0]     d_rem  [QW+1];
    logic [DW-1:0]   d_div  [QW+1];
    logic [QW-1:0]   d_quo  [QW+1];

    vcs_pkg::tag_t   s_tag  [FRACTION_BITS+2];
    logic [QW-1:0]   s_rad  [FRACTION_BITS+2];
    logic [QW-1:0]   s_root [FRACTION_BITS+2];
    logic [QW-1:0]   s_rsq  [FRACTION_BITS+2];

    logic              done_reg;
    vcs_pkg::result_t  result_reg;
    vcs_pkg::result_t  result_next;
    logic [63:0]       root_wide;
    logic [63:0]       mag;

    vcs_front #(.CW(COORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .request   (request),
        .tag       (front_tag),
        .norm_prod (norm_prod),
        .dot_sq    (dot_sq)
    );

    assign d_tag[0] = front_tag;
    assign d_rem[0] = {2'b00, dot_sq[DW-1:1]};
    assign d_div[0] = norm_prod;
    assign d_quo[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        vcs_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tag_in      (d_tag[i]),
            .rem_in      (d_rem[i]),
            .shift_in    ((i == 0) ? dot_sq[0] : 1'b0),
            .divisor_in  (d_div[i]),
            .quo_in      (d_quo[i]),
            .tag_out     (d_tag[i+1]),
            .rem_out     (d_rem[i+1]),
            .divisor_out (d_div[i+1]),
            .quo_out     (d_quo[i+1])
        );
    end

    assign s_tag[0]  = d_tag[QW];
    assign s_rad[0]  = d_quo[QW];
    assign s_root[0] = '0;
    assign s_rsq[0]  = '0;

    for (genvar j = 0; j <= FRACTION_BITS; j++)
    begin : g_sqrt
        vcs_sqrt_cell #(.QW(QW), .K(FRACTION_BITS - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (s_tag[j]),
            .rad_in   (s_rad[j]),
            .root_in  (s_root[j]),
            .rsq_in   (s_rsq[j]),
            .tag_out  (s_tag[j+1]),
            .rad_out  (s_rad[j+1]),
            .root_out (s_root[j+1]),
            .rsq_out  (s_rsq[j+1])
        );
    end

    always_comb
    begin
        root_wide = 64'(s_root[FRACTION_BITS+1]);
        if (s_tag[FRACTION_BITS+1].neg)
        begin
            mag = (root_wide > TOP_NEG) ? TOP_NEG : root_wide;
            result_next.cosine = FW'(64'h10000 - mag);
        end
        else
        begin
            mag = (root_wide > TOP_POS) ? TOP_POS : root_wide;
            result_next.cosine = FW'(mag);
        end
        result_next.zero_vector = s_tag[FRACTION_BITS+1].zero;
        if (s_tag[FRACTION_BITS+1].zero)
        begin
            result_next.cosine = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s_tag[FRACTION_BITS+1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result missing after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without request");

    a_zero_cos: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_vector |-> result.cosine == '0)
        else $error("zero vector with nonzero cosine");
`endif

endmodule

`default_nettype wire
